FILE: sv/mcr_pkg.sv
// ----------------------------------------------------------------------------
// Mecanum command receiver package
// Word types, register indexes and frame constants shared by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package mcr_pkg;

    typedef enum logic
    {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    typedef struct packed
    {
        opcode_t    opcode;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed
    {
        logic signed [15:0] left_front_drive;
        logic signed [15:0] left_rear_drive;
        logic signed [15:0] right_front_drive;
        logic signed [15:0] right_rear_drive;
        logic               from_timeout;
        logic               link_up;
    } out_word_t;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SYNC_VALUE    = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TIMEOUT_TICKS = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DRIVE_LIMIT   = 2'd2;

    localparam logic [7:0]  SYNC_VALUE_RESET    = 8'hAA;
    localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd500;
    localparam logic [14:0] DRIVE_LIMIT_RESET   = 15'd1000;

    localparam logic [2:0] COUNT_HUNT = 3'd0;
    localparam logic [2:0] COUNT_LAST = 3'd6;

    localparam int PAYLOAD_DEPTH = 5;

    localparam logic [15:0] IDLE_MAX = 16'hFFFF;

endpackage : mcr_pkg

`default_nettype wire

FILE: sv/mcr_mixer.sv
// ----------------------------------------------------------------------------
// Mecanum mixer
// Mixes forward, strafe and turn into four wheel drives and clamps each one
// to plus or minus the drive limit.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_mixer
    import mcr_pkg::*;
(
    input  wire logic signed [15:0] forward,
    input  wire logic signed [15:0] strafe,
    input  wire logic signed [15:0] turn,
    input  wire logic        [14:0] limit,
    output logic signed [15:0]      left_front,
    output logic signed [15:0]      left_rear,
    output logic signed [15:0]      right_front,
    output logic signed [15:0]      right_rear
);

    logic signed [17:0] f_ext;
    logic signed [17:0] s_ext;
    logic signed [17:0] t_ext;
    logic signed [17:0] lim_pos;
    logic signed [17:0] lim_neg;

    function automatic logic signed [15:0] clamp(input logic signed [17:0] v,
                                                 input logic signed [17:0] hi,
                                                 input logic signed [17:0] lo);
        logic signed [17:0] r;
        begin
            if (v > hi)
            begin
                r = hi;
            end
            else if (v < lo)
            begin
                r = lo;
            end
            else
            begin
                r = v;
            end
            return r[15:0];
        end
    endfunction

    always_comb
    begin
        f_ext   = 18'(forward);
        s_ext   = 18'(strafe);
        t_ext   = 18'(turn);
        lim_pos = $signed({3'b000, limit});
        lim_neg = -lim_pos;

        left_front  = clamp(s_ext - f_ext - t_ext, lim_pos, lim_neg);
        left_rear   = clamp(-f_ext - s_ext - t_ext, lim_pos, lim_neg);
        right_front = clamp(f_ext + s_ext - t_ext, lim_pos, lim_neg);
        right_rear  = clamp(f_ext - s_ext - t_ext, lim_pos, lim_neg);
    end

endmodule : mcr_mixer

`default_nettype wire

FILE: sv/mecanum_command_receiver_top.sv
// ----------------------------------------------------------------------------
// Mecanum command receiver
// Frames serial bytes behind a sync byte, mixes each complete frame into four
// wheel drives and issues a stop command when the link goes idle.
//
//   Port group   Direction  Handshake              Carries
//   in_*         in         in_valid / in_ready    in_word_t: byte or tick
//   out_*        out        out_valid / out_ready  out_word_t: drive command
//   cfg_*        in         cfg_write              register index and value
//
// Each word waits in the input register, then is decoded, mixed and clamped in a
// single pass into the result register: one word per cycle unless output stalls.
// A word leaves the input register only when the result register is empty or
// being read, so a stalled output holds at most two words inside the block.
// Reset clears framing, link state and the idle counter; registers return to
// sync 0xAA, timeout 500 ticks and limit 1000.
// ----------------------------------------------------------------------------
`default_nettype none

module mecanum_command_receiver_top
    import mcr_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire in_word_t                   in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output out_word_t                       out_data,
    input  wire logic                       cfg_write,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    logic [7:0]  sync_value_reg;
    logic [15:0] timeout_ticks_reg;
    logic [14:0] drive_limit_reg;

    logic        in_valid_reg;
    in_word_t    in_word_reg;
    logic        out_valid_reg;
    out_word_t   out_word_reg;

    logic [2:0]  byte_count_reg;
    logic [2:0]  byte_count_next;
    logic        connected_reg;
    logic        connected_next;
    logic [15:0] idle_ticks_reg;
    logic [15:0] idle_ticks_next;
    logic [7:0]  payload_reg [PAYLOAD_DEPTH];

    logic        proc_fire;
    logic        is_byte;
    logic        store_byte;
    logic        frame_done;
    logic        stop_hit;
    logic [15:0] idle_inc;
    logic [2:0]  store_index;
    out_word_t   out_word_next;

    logic signed [15:0] mix_lf;
    logic signed [15:0] mix_lr;
    logic signed [15:0] mix_rf;
    logic signed [15:0] mix_rr;

    assign proc_fire = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || proc_fire;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    mcr_mixer u_mixer
    (
        .forward     ($signed({payload_reg[1], payload_reg[0]})),
        .strafe      ($signed({payload_reg[3], payload_reg[2]})),
        .turn        ($signed({in_word_reg.rx_byte, payload_reg[4]})),
        .limit       (drive_limit_reg),
        .left_front  (mix_lf),
        .left_rear   (mix_lr),
        .right_front (mix_rf),
        .right_rear  (mix_rr)
    );

    always_comb
    begin
        is_byte     = (in_word_reg.opcode == OP_BYTE);
        store_index = byte_count_reg - 3'd1;
        store_byte  = is_byte && (byte_count_reg != COUNT_HUNT)
                      && (byte_count_reg != COUNT_LAST);
        frame_done  = is_byte && (byte_count_reg == COUNT_LAST);
        idle_inc    = (idle_ticks_reg == IDLE_MAX) ? idle_ticks_reg
                                                   : idle_ticks_reg + 16'd1;
        stop_hit    = !is_byte && connected_reg && (idle_inc >= timeout_ticks_reg);

        byte_count_next = byte_count_reg;
        connected_next  = connected_reg;
        idle_ticks_next = idle_ticks_reg;

        if (is_byte)
        begin
            if (byte_count_reg == COUNT_HUNT)
            begin
                if (in_word_reg.rx_byte == sync_value_reg)
                begin
                    byte_count_next = 3'd1;
                end
            end
            else if (frame_done)
            begin
                byte_count_next = COUNT_HUNT;
                connected_next  = 1'b1;
                idle_ticks_next = '0;
            end
            else
            begin
                byte_count_next = byte_count_reg + 3'd1;
            end
        end
        else if (connected_reg)
        begin
            idle_ticks_next = idle_inc;
            if (stop_hit)
            begin
                connected_next = 1'b0;
            end
        end

        if (frame_done)
        begin
            out_word_next.left_front_drive  = mix_lf;
            out_word_next.left_rear_drive   = mix_lr;
            out_word_next.right_front_drive = mix_rf;
            out_word_next.right_rear_drive  = mix_rr;
            out_word_next.from_timeout      = 1'b0;
            out_word_next.link_up           = 1'b1;
        end
        else
        begin
            out_word_next.left_front_drive  = '0;
            out_word_next.left_rear_drive   = '0;
            out_word_next.right_front_drive = '0;
            out_word_next.right_rear_drive  = '0;
            out_word_next.from_timeout      = 1'b1;
            out_word_next.link_up           = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_value_reg    <= SYNC_VALUE_RESET;
            timeout_ticks_reg <= TIMEOUT_TICKS_RESET;
            drive_limit_reg   <= DRIVE_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SYNC_VALUE:    sync_value_reg    <= cfg_data[7:0];
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[15:0];
                CFG_DRIVE_LIMIT:   drive_limit_reg   <= cfg_data[14:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            byte_count_reg <= COUNT_HUNT;
            connected_reg  <= 1'b0;
            idle_ticks_reg <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc_fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (proc_fire)
            begin
                out_valid_reg  <= frame_done || stop_hit;
                byte_count_reg <= byte_count_next;
                connected_reg  <= connected_next;
                idle_ticks_reg <= idle_ticks_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_word_reg <= in_data;
        end
        if (proc_fire)
        begin
            out_word_reg <= out_word_next;
            if (store_byte)
            begin
                payload_reg[store_index] <= in_word_reg.rx_byte;
            end
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= COUNT_LAST)
        else $error("Frame byte count ran past the last payload byte.");

    assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && frame_done |=> connected_reg && (idle_ticks_reg == 16'd0))
        else $error("A completed frame did not bring the link up with a clear count.");

    assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && stop_hit |=> !connected_reg && out_valid_reg
        && out_word_reg.from_timeout)
        else $error("A timeout did not drop the link and post a stop command.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_word_reg.from_timeout |->
        (out_word_reg.left_front_drive == 16'sd0) && (out_word_reg.left_rear_drive == 16'sd0)
        && (out_word_reg.right_front_drive == 16'sd0)
        && (out_word_reg.right_rear_drive == 16'sd0))
        else $error("A stop command carried a nonzero drive.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_word_reg.from_timeout |->
        ($signed(out_word_reg.right_rear_drive) <= $signed({1'b0, drive_limit_reg}))
        && ($signed(out_word_reg.right_rear_drive) >= -$signed({1'b0, drive_limit_reg})))
        else $error("A frame drive exceeded the drive limit.");
`endif

endmodule : mecanum_command_receiver_top

`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Mecanum command receiver testbench
// Streams serial bytes and ticks into the receiver through its input handshake
// and predicts every drive frame and stop command from a local copy of the
// framing, mixing, clamping and idle-timeout behavior. Each command that
// leaves the block is compared field by field with the oldest prediction.
// Directed tests cover field extremes, sync bytes inside a frame, register
// extremes and masked register bits, and an unused register index. Random
// phases then mix well-formed frames, tick bursts, noise and broken frames
// under several register settings, with random idling on both sides and one
// phase without idling.
// ----------------------------------------------------------------------------
module tb_top
    import mcr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int IDLE_PERCENT = 16;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    in_word_t                   in_data = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    out_word_t                  out_data;
    logic                       cfg_write = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

    logic [7:0]  sync_byte_cfg = SYNC_VALUE_RESET;
    logic [15:0] stop_ticks_cfg = TIMEOUT_TICKS_RESET;
    logic [14:0] limit_cfg = DRIVE_LIMIT_RESET;
    logic [2:0]  frame_pos = COUNT_HUNT;
    logic [7:0]  frame_bytes [6];
    logic        link_is_up = 1'b0;
    logic [15:0] idle_count = '0;

    out_word_t expected_cmds [$];
    logic      steady = 1'b0;
    int        words_sent = 0;
    int        frames_seen = 0;
    int        stops_seen = 0;
    int        mismatch_count = 0;

    mecanum_command_receiver_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic logic signed [15:0] limit_mix(int v);
        int lim;
        lim = int'(limit_cfg);
        if (v > lim)
            v = lim;
        else if (v < -lim)
            v = -lim;
        return 16'(v);
    endfunction

    function automatic int payload_word(int pos);
        logic signed [15:0] w;
        int                 v;
        w = {frame_bytes[pos + 1], frame_bytes[pos]};
        v = w;
        return v;
    endfunction

    function automatic void apply_config(logic [CFG_INDEX_WIDTH-1:0] index,
                                         logic [CFG_DATA_WIDTH-1:0] data);
        case (index)
            CFG_SYNC_VALUE:    sync_byte_cfg = data[7:0];
            CFG_TIMEOUT_TICKS: stop_ticks_cfg = data;
            CFG_DRIVE_LIMIT:   limit_cfg = data[14:0];
            default:           ;
        endcase
    endfunction

    function automatic void apply_word(in_word_t w);
        out_word_t cmd;
        int        f;
        int        s;
        int        t;
        cmd = '0;
        if (w.opcode == OP_BYTE)
        begin
            if (frame_pos == COUNT_HUNT)
            begin
                if (w.rx_byte == sync_byte_cfg)
                    frame_pos = 3'd1;
            end
            else
            begin
                frame_bytes[frame_pos - 3'd1] = w.rx_byte;
                if (frame_pos == COUNT_LAST)
                begin
                    frame_pos = COUNT_HUNT;
                    f = payload_word(0);
                    s = payload_word(2);
                    t = payload_word(4);
                    cmd.left_front_drive  = limit_mix(-(f - s + t));
                    cmd.left_rear_drive   = limit_mix(-(f + s + t));
                    cmd.right_front_drive = limit_mix(f + s - t);
                    cmd.right_rear_drive  = limit_mix(f - s - t);
                    cmd.link_up = 1'b1;
                    link_is_up = 1'b1;
                    idle_count = '0;
                    expected_cmds.push_back(cmd);
                end
                else
                    frame_pos = frame_pos + 3'd1;
            end
        end
        else if (link_is_up)
        begin
            if (idle_count != IDLE_MAX)
                idle_count = idle_count + 16'd1;
            if (idle_count >= stop_ticks_cfg)
            begin
                link_is_up = 1'b0;
                cmd.from_timeout = 1'b1;
                expected_cmds.push_back(cmd);
            end
        end
    endfunction

    task automatic report_field(string name, logic signed [15:0] want,
                                logic signed [15:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic check_cmd(out_word_t got);
        out_word_t want;
        if (expected_cmds.size() == 0)
        begin
            mismatch_count++;
            $display("%0t: unexpected command, expected none, actual %p", $time, got);
        end
        else
        begin
            want = expected_cmds.pop_front();
            report_field("left_front_drive", want.left_front_drive, got.left_front_drive);
            report_field("left_rear_drive", want.left_rear_drive, got.left_rear_drive);
            report_field("right_front_drive", want.right_front_drive, got.right_front_drive);
            report_field("right_rear_drive", want.right_rear_drive, got.right_rear_drive);
            report_field("from_timeout", 16'(want.from_timeout), 16'(got.from_timeout));
            report_field("link_up", 16'(want.link_up), 16'(got.link_up));
            if (want.from_timeout)
                stops_seen++;
            else
                frames_seen++;
        end
    endtask

    task automatic send_word(in_word_t w);
        if (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 20);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        apply_word(w);
        words_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_word('{opcode: OP_BYTE, rx_byte: b});
    endtask

    task automatic send_tick();
        send_word('{opcode: OP_TICK, rx_byte: 8'($urandom)});
    endtask

    task automatic send_frame(logic [15:0] f, logic [15:0] s, logic [15:0] t);
        send_byte(sync_byte_cfg);
        send_byte(f[7:0]);
        send_byte(f[15:8]);
        send_byte(s[7:0]);
        send_byte(s[15:8]);
        send_byte(t[7:0]);
        send_byte(t[15:8]);
    endtask

    task automatic settle_block();
        in_valid <= 1'b0;
        while (expected_cmds.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_WIDTH-1:0] index,
                                  logic [CFG_DATA_WIDTH-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        apply_config(index, data);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(3))
            0:
            begin
                return 16'($urandom_range(0, 2200) - 1100);
            end
            1:
            begin
                case ($urandom_range(3))
                    0:       return 16'h7FFF;
                    1:       return 16'h8000;
                    2:       return 16'hFFFF;
                    default: return 16'h0000;
                endcase
            end
            default:
            begin
                return 16'($urandom);
            end
        endcase
    endfunction

    task automatic test_default_frames();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_tick();
        send_frame(16'h7FFF, 16'h8000, 16'h0001);
        send_frame(16'hAAAA, 16'h00AA, 16'hAA00);
        send_tick();
        send_tick();
    endtask

    task automatic test_register_extremes();
        settle_block();
        write_register(CFG_DRIVE_LIMIT, 16'hFFFF);
        write_register(CFG_SYNC_VALUE, 16'hFF00);
        write_register(CFG_TIMEOUT_TICKS, 16'd0);
        write_register(CFG_UNUSED_INDEX, 16'h1234);
        send_frame(16'h7FFF, 16'h7FFF, 16'h8000);
        send_frame(16'h8000, 16'h8000, 16'h7FFF);
        send_tick();
        send_tick();
        settle_block();
        write_register(CFG_DRIVE_LIMIT, 16'd0);
        write_register(CFG_TIMEOUT_TICKS, 16'd1);
        send_frame(16'h1234, 16'hFEDC, 16'h8001);
        send_tick();
        settle_block();
        write_register(CFG_DRIVE_LIMIT, 16'd1);
        write_register(CFG_TIMEOUT_TICKS, 16'd2);
        send_frame(16'h0002, 16'hFFFE, 16'h0000);
        send_tick();
        send_tick();
    endtask

    task automatic test_random_traffic();
        int          phase;
        int          budget;
        int          pick;
        int          burst;
        int          n;
        logic [7:0]  sync_pick;
        logic [15:0] ticks_pick;
        logic [14:0] limit_pick;
        for (phase = 0; phase < 6; phase++)
        begin
            sync_pick  = 8'($urandom);
            ticks_pick = 16'($urandom_range(0, 24));
            limit_pick = 15'($urandom_range(1, 32767));
            case (phase)
                1:
                begin
                    sync_pick  = 8'h00;
                    ticks_pick = 16'd0;
                    limit_pick = 15'd1;
                end
                2:
                begin
                    sync_pick  = 8'hFF;
                    ticks_pick = 16'hFFFF;
                    limit_pick = 15'h7FFF;
                end
                3:
                begin
                    limit_pick = 15'd0;
                end
                default:
                begin
                end
            endcase
            settle_block();
            write_register(CFG_SYNC_VALUE, {8'($urandom), sync_pick});
            write_register(CFG_TIMEOUT_TICKS, ticks_pick);
            write_register(CFG_DRIVE_LIMIT, {1'($urandom), limit_pick});
            steady = (phase == 4);
            budget = words_sent + 150;
            while (words_sent < budget)
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                    send_frame(pick_value(), pick_value(), pick_value());
                else if (pick < 80)
                begin
                    burst = $urandom_range(1, (stop_ticks_cfg < 28) ? stop_ticks_cfg + 3 : 30);
                    for (n = 0; n < burst; n++)
                        send_tick();
                end
                else if (pick < 90)
                    send_byte(8'($urandom));
                else
                begin
                    send_byte(sync_byte_cfg);
                    burst = $urandom_range(0, 5);
                    for (n = 0; n < burst; n++)
                        send_byte(8'($urandom));
                end
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                check_cmd(out_data);
            out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_frames();
        test_register_extremes();
        test_random_traffic();
        settle_block();
        repeat (8) @(posedge clk);
        $display("Summary: %0d words sent, %0d drive frames and %0d stop commands checked.",
                 words_sent, frames_seen, stops_seen);
        $display("Covered clamp extremes, masked and unused register writes, and timeouts.");
        if (mismatch_count == 0 && expected_cmds.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
